FILE: design/adjacent_swap_distance_core_defines.svh
// Assertion macros shared by the adjacent swap distance core.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ADJACENT_SWAP_DISTANCE_CORE_DEFINES_SVH
`define ADJACENT_SWAP_DISTANCE_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define ASDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/asdc_pkg.sv
// Shared types and constants of the adjacent swap distance core.
// No dependencies; used by the cell, the tally and the top level.
`timescale 1ns / 1ps
`default_nettype none

package asdc_pkg;

  // Default sizes
  localparam int MAX_LEN_DEF = 1024;
  localparam int KEY_W_DEF   = 32;

  // Stream field widths
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int SWAP_W      = 19;
  localparam int OUT_TDATA_W = 24;
  localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

  // Item kind carried on tuser
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SOURCE = 1'b1
  } asdc_func_t;

  // Control part of a token moving down the chain
  typedef struct packed {
    logic       valid;
    asdc_func_t func;
    logic       last;
    logic       hit;   // load: cell claimed; source: match found
  } asdc_tok_t;

  // Status from the tally
  typedef struct packed {
    logic emit;
    logic clean;
  } asdc_stat_t;

endpackage

`default_nettype wire

FILE: design/asdc_cell.sv
// One cell of the matching chain: holds one target entry and passes tokens on.
// Depends on asdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asdc_cell #(
  parameter int KEY_WIDTH = asdc_pkg::KEY_W_DEF,
  parameter int LATER_W   = 10
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     adv,
  input  asdc_pkg::asdc_tok_t     tok_i,
  input  wire [2*KEY_WIDTH-1:0]   key_i,
  input  wire [LATER_W-1:0]       later_i,
  output asdc_pkg::asdc_tok_t     tok_o,
  output logic [2*KEY_WIDTH-1:0]  key_o,
  output logic [LATER_W-1:0]      later_o
);
  import asdc_pkg::*;

  logic                   valid_r, valid_nxt;
  logic                   used_r, used_nxt;
  logic [2*KEY_WIDTH-1:0] key_r, key_nxt;
  asdc_tok_t              tok_r, tok_nxt;
  logic [2*KEY_WIDTH-1:0] tkey_r, tkey_nxt;
  logic [LATER_W-1:0]     later_r, later_nxt;
  logic                   match;

  assign match = valid_r && !used_r && (key_r == key_i);

  // Act on the incoming token and advance it by one cell
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    key_nxt   = key_r;
    tok_nxt   = tok_r;
    tkey_nxt  = tkey_r;
    later_nxt = later_r;
    if (adv) begin
      tok_nxt   = tok_i;
      tkey_nxt  = key_i;
      later_nxt = later_i;
      if (tok_i.valid) begin
        unique case (tok_i.func)
          FUNC_LOAD: begin
            // claim the first free cell
            if (!tok_i.hit && !valid_r) begin
              valid_nxt   = 1'b1;
              used_nxt    = 1'b0;
              key_nxt     = key_i;
              tok_nxt.hit = 1'b1;
            end
          end
          FUNC_SOURCE: begin
            // take the earliest unused equal entry, then count used ones behind it
            if (!tok_i.hit && match) begin
              used_nxt    = 1'b1;
              tok_nxt.hit = 1'b1;
            end else if (tok_i.hit && valid_r && used_r) begin
              later_nxt = later_i + 1'b1;
            end
            // the closing item empties every cell it passes
            if (tok_i.last) begin
              valid_nxt = 1'b0;
              used_nxt  = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      used_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    tkey_r  <= tkey_nxt;
    later_r <= later_nxt;
  end

  assign tok_o   = tok_r;
  assign key_o   = tkey_r;
  assign later_o = later_r;

endmodule

`default_nettype wire

FILE: design/asdc_tally.sv
// Exit side of the chain: counts items, sums inversions, holds the result register.
// Depends on asdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asdc_tally #(
  parameter int MAX_LEN = asdc_pkg::MAX_LEN_DEF,
  parameter int LATER_W = 10
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  asdc_pkg::asdc_tok_t                  tok_i,
  input  wire [LATER_W-1:0]                    later_i,
  input  wire                                  out_tready,
  output logic                                 adv,
  output logic                                 out_tvalid,
  output logic [asdc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output asdc_pkg::asdc_stat_t                 stat
);
  import asdc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 2);
  localparam int SUM_W = SWAP_W + 1;

  logic [CNT_W-1:0]  tgt_cnt_r, tgt_cnt_nxt;
  logic [CNT_W-1:0]  src_cnt_r, src_cnt_nxt;
  logic [SWAP_W-1:0] total_r, total_nxt;
  logic              failed_r, failed_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SWAP_W-1:0] out_swap_r, out_swap_nxt;
  logic              out_match_r, out_match_nxt;
  logic              exit_last;
  logic              ok;
  logic [SUM_W-1:0]  sum;

  assign exit_last = tok_i.valid && (tok_i.func == FUNC_SOURCE) && tok_i.last;
  // Hold the chain only while a result waits and another one arrives
  assign adv = !(exit_last && out_valid_r && !out_tready);

  assign sum = {1'b0, total_r} + SUM_W'(later_i);

  // Account for the token leaving the chain
  always_comb begin
    tgt_cnt_nxt   = tgt_cnt_r;
    src_cnt_nxt   = src_cnt_r;
    total_nxt     = total_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_swap_nxt  = out_swap_r;
    out_match_nxt = out_match_r;
    ok            = 1'b0;
    if (adv && tok_i.valid) begin
      unique case (tok_i.func)
        FUNC_LOAD: begin
          if (tok_i.hit) tgt_cnt_nxt = tgt_cnt_r + 1'b1;
          else           failed_nxt  = 1'b1;
        end
        FUNC_SOURCE: begin
          if (src_cnt_r <= CNT_W'(MAX_LEN)) src_cnt_nxt = src_cnt_r + 1'b1;
          if (tok_i.hit) begin
            total_nxt = sum[SWAP_W] ? SWAP_MAX : sum[SWAP_W-1:0];
          end else begin
            failed_nxt = 1'b1;
          end
          if (tok_i.last) begin
            ok            = !failed_nxt && (src_cnt_nxt == tgt_cnt_r);
            out_valid_nxt = 1'b1;
            out_swap_nxt  = ok ? total_nxt : '0;
            out_match_nxt = ok;
            tgt_cnt_nxt   = '0;
            src_cnt_nxt   = '0;
            total_nxt     = '0;
            failed_nxt    = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_cnt_r   <= '0;
      src_cnt_r   <= '0;
      total_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tgt_cnt_r   <= tgt_cnt_nxt;
      src_cnt_r   <= src_cnt_nxt;
      total_r     <= total_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_swap_r  <= out_swap_nxt;
    out_match_r <= out_match_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - SWAP_W - 1)'(0), out_match_r, out_swap_r};

  assign stat.emit  = adv && exit_last;
  assign stat.clean = (tgt_cnt_r == '0) && (src_cnt_r == '0) && (total_r == '0) && !failed_r;

endmodule

`default_nettype wire

FILE: design/adjacent_swap_distance_core.sv
// Adjacent swap distance core: a chain of match cells and an exit tally.
// Depends on asdc_pkg, asdc_cell, asdc_tally and adjacent_swap_distance_core_defines.svh.
//
// Usage: items arrive on the in_ stream. in_tuser = 0 loads a target entry,
// in_tuser = 1 presents a source entry; in_tlast on a source entry closes the
// run. Each closing source entry yields one transfer on the out_ stream with
// the inversion count and the matched flag; it is zero when unmatched.
// Every item travels down a row of MAX_LEN cells, one cell per cycle unless the
// row holds. Each cell stores one target pair and its used mark, compares the
// passing key and counts used entries behind a match. Items follow each other
// with no gap, so one item is taken every cycle unless in_tready is low.
// The tally registers a result once its closing item has left the last cell.
// Reset (rst_n low, synchronous) empties all cells and counters; no clearing
// pass follows. The closing item empties each cell as it passes, so the next
// run may start in the cycle after it. While a result waits in the output
// register and the next result reaches the end of the row, the whole row and
// in_tready hold until out_tready takes the waiting one.
`timescale 1ns / 1ps
`default_nettype none
`include "adjacent_swap_distance_core_defines.svh"

module adjacent_swap_distance_core #(
  parameter int MAX_LEN   = asdc_pkg::MAX_LEN_DEF,
  parameter int KEY_WIDTH = asdc_pkg::KEY_W_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [asdc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] first_value, [63:32] second_value
  input  wire                                in_tuser,   // [0] func
  input  wire                                in_tlast,   // last
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [asdc_pkg::OUT_TDATA_W-1:0]   out_tdata   // [18:0] swap_count, [19] matched, zeros
);
  import asdc_pkg::*;

  localparam int LATER_W = $clog2(MAX_LEN);

  asdc_tok_t              tok   [MAX_LEN+1];
  logic [2*KEY_WIDTH-1:0] key   [MAX_LEN+1];
  logic [LATER_W-1:0]     later [MAX_LEN+1];
  logic                   adv;
  asdc_stat_t             stat;

  // Feed the head of the row straight from the input port
  assign tok[0].valid = in_tvalid;
  assign tok[0].func  = asdc_func_t'(in_tuser);
  assign tok[0].last  = in_tuser && in_tlast;
  assign tok[0].hit   = 1'b0;
  assign key[0]   = {in_tdata[FIELD_W +: KEY_WIDTH], in_tdata[0 +: KEY_WIDTH]};
  assign later[0] = '0;

  assign in_tready = adv;

  // Row of match cells
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    asdc_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .LATER_W   (LATER_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_i   (tok[i]),
      .key_i   (key[i]),
      .later_i (later[i]),
      .tok_o   (tok[i+1]),
      .key_o   (key[i+1]),
      .later_o (later[i+1])
    );
  end

  // Exit accounting and result register
  asdc_tally #(
    .MAX_LEN (MAX_LEN),
    .LATER_W (LATER_W)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_i      (tok[MAX_LEN]),
    .later_i    (later[MAX_LEN]),
    .out_tready (out_tready),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

  // Input stalls only behind a waiting result
  `ASDC_ASSERT_NOW(a_stall_cause, !in_tready, out_tvalid && !out_tready, "input stalled without a waiting result")
  // An unmatched result carries a zero count
  `ASDC_ASSERT_NOW(a_unmatched_zero, out_tvalid && !out_tdata[SWAP_W], out_tdata[SWAP_W-1:0] == '0, "unmatched result with nonzero count")
  // Counters return to reset values after a result
  `ASDC_ASSERT_NEXT(a_clear_after_emit, stat.emit, stat.clean, "tally not cleared after result")

endmodule

`default_nettype wire
